[rtl/gau_pkg.sv]
`timescale 1ns / 1ps
package gau_pkg;

  localparam int ValueBits    = 32;
  localparam int WeightBits   = 16;
  localparam int FractionBits = 16;
  localparam int AccBits      = 64;
  localparam int WtBits       = 48;
  localparam int CntBits      = 32;
  localparam int CfgIdxBits   = 2;
  localparam int QueueDepth   = 2;
  localparam int QueuePtrBits = 1;
  // Numerator width: 64-bit magnitude times 100 (7 bits) shifted by the fraction bits.
  localparam int NumBits      = AccBits + 7 + FractionBits;
  localparam int NumCntBits   = $clog2(NumBits + 1);

  localparam logic [WtBits-1:0]  WtMax  = {WtBits{1'b1}};
  localparam logic [CntBits-1:0] CntMax = {CntBits{1'b1}};
  localparam logic [6:0]         PctScale = 7'd100;

  typedef enum logic [4:0] {
    FN_SUM    = 5'd0,
    FN_MEAN   = 5'd1,
    FN_MAX    = 5'd2,
    FN_MIN    = 5'd3,
    FN_PGT    = 5'd4,
    FN_PLT    = 5'd5,
    FN_PIN    = 5'd6,
    FN_POUT   = 5'd7,
    FN_FGT    = 5'd8,
    FN_FLT    = 5'd9,
    FN_FIN    = 5'd10,
    FN_FOUT   = 5'd11,
    FN_N      = 5'd12,
    FN_NU     = 5'd13,
    FN_NMISS  = 5'd14,
    FN_NUMISS = 5'd15,
    FN_FIRST  = 5'd16,
    FN_LAST   = 5'd17
  } func_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_FUNC   = 2'd0,
    REG_LOW    = 2'd1,
    REG_HIGH   = 2'd2,
    REG_COLWISE = 2'd3
  } reg_e;

  typedef struct packed {
    logic signed [ValueBits-1:0] sample_value;
    logic [WeightBits-1:0]       case_weight;
    logic                        is_missing;
    logic                        last_in_group;
  } in_item_t;

  typedef struct packed {
    logic signed [AccBits-1:0] agg_result;
    logic                      agg_missing;
    logic                      agg_saturated;
  } out_item_t;

  // Classified operation passed from the front end to the back end.
  typedef struct packed {
    logic [4:0]                  func;
    logic signed [ValueBits-1:0] value;
    logic [WeightBits-1:0]       weight;
    logic                        missing;
    logic                        hit;
    logic                        last;
  } op_t;

  typedef struct packed {
    logic signed [AccBits-1:0] acc;
    logic [WtBits-1:0]         wt;
    logic [CntBits-1:0]        cnt;
    logic                      value_seen;
    logic                      missing_seen;
    logic                      sat_seen;
    logic [4:0]                func;
    logic                      columnwise;
  } group_t;

endpackage

[rtl/gau_front.sv]
`timescale 1ns / 1ps
module gau_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gau_pkg::in_item_t in_data_i,
  input  logic [4:0]        func_i,
  input  logic signed [31:0] arg_low_i,
  input  logic signed [31:0] arg_high_i,
  output logic              op_valid_o,
  input  logic              op_ready_i,
  output gau_pkg::op_t      op_o
);

  gau_pkg::op_t mem_q [gau_pkg::QueueDepth];
  logic [gau_pkg::QueuePtrBits-1:0] wr_q, rd_q;
  logic [gau_pkg::QueuePtrBits:0]   cnt_q;
  logic signed [31:0] lo, hi;
  logic hit;
  logic push, pop;
  gau_pkg::op_t op;

  assign lo = (arg_low_i < arg_high_i) ? arg_low_i : arg_high_i;
  assign hi = (arg_low_i < arg_high_i) ? arg_high_i : arg_low_i;

  // Classify the sample against the threshold or range.
  always_comb begin
    case (func_i)
      gau_pkg::FN_PGT, gau_pkg::FN_FGT: hit = in_data_i.sample_value > arg_low_i;
      gau_pkg::FN_PLT, gau_pkg::FN_FLT: hit = in_data_i.sample_value < arg_low_i;
      gau_pkg::FN_PIN, gau_pkg::FN_FIN:
        hit = (lo <= in_data_i.sample_value) && (in_data_i.sample_value <= hi);
      default: hit = (in_data_i.sample_value < lo) || (in_data_i.sample_value > hi);
    endcase
  end

  always_comb begin
    op.func    = func_i;
    op.value   = in_data_i.sample_value;
    op.weight  = in_data_i.case_weight;
    op.missing = in_data_i.is_missing;
    op.hit     = hit;
    op.last    = in_data_i.last_in_group;
  end

  assign in_ready_o = (cnt_q != (gau_pkg::QueuePtrBits+1)'(gau_pkg::QueueDepth));
  assign push = in_valid_i && in_ready_o;
  assign op_valid_o = (cnt_q != '0);
  assign pop = op_valid_o && op_ready_i;
  assign op_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (gau_pkg::QueuePtrBits+1)'(push) - (gau_pkg::QueuePtrBits+1)'(pop);
    end
  end

endmodule

[rtl/gau_accum.sv]
`timescale 1ns / 1ps
module gau_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              columnwise_i,
  input  logic              op_valid_i,
  output logic              op_ready_o,
  input  gau_pkg::op_t      op_i,
  output logic              grp_valid_o,
  input  logic              grp_ready_i,
  output gau_pkg::group_t   grp_o
);

  logic signed [gau_pkg::AccBits-1:0] acc_q, acc_d;
  logic [gau_pkg::WtBits-1:0]  wt_q, wt_d;
  logic [gau_pkg::CntBits-1:0] cnt_q, cnt_d;
  logic vseen_q, vseen_d, mseen_q, mseen_d, sat_q, sat_d;
  logic grp_valid_q;
  gau_pkg::group_t grp_q;

  logic signed [47:0] prod;
  logic signed [gau_pkg::AccBits-1:0] addend;
  logic signed [gau_pkg::AccBits:0]   sum_ext;
  logic add_en, wt_en, cnt_en, ovf;
  logic [gau_pkg::WtBits:0] wt_sum;
  logic take;

  assign prod = op_i.value * $signed({1'b0, op_i.weight});
  assign op_ready_o = !grp_valid_q || grp_ready_i;
  assign take = op_valid_i && op_ready_o;

  always_comb begin
    addend = gau_pkg::AccBits'($signed({1'b0, op_i.weight}));
    add_en = 1'b0;
    wt_en  = 1'b0;
    cnt_en = 1'b0;
    acc_d  = acc_q;
    vseen_d = vseen_q;
    mseen_d = mseen_q || op_i.missing;
    if (op_i.missing) begin
      add_en = (op_i.func == gau_pkg::FN_NMISS);
      cnt_en = (op_i.func == gau_pkg::FN_NUMISS);
    end else begin
      case (op_i.func)
        gau_pkg::FN_SUM: begin
          addend = gau_pkg::AccBits'(prod);
          add_en = 1'b1;
          vseen_d = 1'b1;
        end
        gau_pkg::FN_MEAN: begin
          addend = gau_pkg::AccBits'(prod);
          add_en = 1'b1;
          wt_en = 1'b1;
        end
        gau_pkg::FN_MAX: begin
          if (!vseen_q || gau_pkg::AccBits'(op_i.value) > acc_q)
            acc_d = gau_pkg::AccBits'(op_i.value);
          vseen_d = 1'b1;
        end
        gau_pkg::FN_MIN: begin
          if (!vseen_q || gau_pkg::AccBits'(op_i.value) < acc_q)
            acc_d = gau_pkg::AccBits'(op_i.value);
          vseen_d = 1'b1;
        end
        gau_pkg::FN_PGT, gau_pkg::FN_PLT, gau_pkg::FN_PIN, gau_pkg::FN_POUT,
        gau_pkg::FN_FGT, gau_pkg::FN_FLT, gau_pkg::FN_FIN, gau_pkg::FN_FOUT: begin
          add_en = op_i.hit;
          wt_en = 1'b1;
        end
        gau_pkg::FN_N: add_en = 1'b1;
        gau_pkg::FN_NU: cnt_en = 1'b1;
        gau_pkg::FN_FIRST: begin
          if (!vseen_q) acc_d = gau_pkg::AccBits'(op_i.value);
          vseen_d = 1'b1;
        end
        gau_pkg::FN_LAST: begin
          acc_d = gau_pkg::AccBits'(op_i.value);
          vseen_d = 1'b1;
        end
        default: ;
      endcase
    end
    sum_ext = {acc_q[gau_pkg::AccBits-1], acc_q} + {addend[gau_pkg::AccBits-1], addend};
    ovf = sum_ext[gau_pkg::AccBits] != sum_ext[gau_pkg::AccBits-1];
    sat_d = sat_q;
    if (add_en) begin
      if (ovf) begin
        acc_d = sum_ext[gau_pkg::AccBits] ? {1'b1, {(gau_pkg::AccBits-1){1'b0}}}
                                          : {1'b0, {(gau_pkg::AccBits-1){1'b1}}};
        sat_d = 1'b1;
      end else begin
        acc_d = sum_ext[gau_pkg::AccBits-1:0];
      end
    end
    wt_sum = {1'b0, wt_q} + (gau_pkg::WtBits+1)'(op_i.weight);
    wt_d = wt_q;
    if (wt_en) begin
      if (wt_sum[gau_pkg::WtBits]) begin
        wt_d = gau_pkg::WtMax;
        sat_d = 1'b1;
      end else begin
        wt_d = wt_sum[gau_pkg::WtBits-1:0];
      end
    end
    cnt_d = cnt_q;
    if (cnt_en) begin
      if (cnt_q == gau_pkg::CntMax) sat_d = 1'b1;
      else cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      wt_q <= '0;
      cnt_q <= '0;
      vseen_q <= 1'b0;
      mseen_q <= 1'b0;
      sat_q <= 1'b0;
      grp_valid_q <= 1'b0;
    end else begin
      grp_valid_q <= (take && op_i.last) || (grp_valid_q && !grp_ready_i);
      if (take) begin
        if (op_i.last) begin
          acc_q <= '0;
          wt_q <= '0;
          cnt_q <= '0;
          vseen_q <= 1'b0;
          mseen_q <= 1'b0;
          sat_q <= 1'b0;
        end else begin
          acc_q <= acc_d;
          wt_q <= wt_d;
          cnt_q <= cnt_d;
          vseen_q <= vseen_d;
          mseen_q <= mseen_d;
          sat_q <= sat_d;
        end
      end
    end
  end

  // Snapshot the finished group for the divider.
  always_ff @(posedge clk_i) begin
    if (take && op_i.last) begin
      grp_q.acc <= acc_d;
      grp_q.wt <= wt_d;
      grp_q.cnt <= cnt_d;
      grp_q.value_seen <= vseen_d;
      grp_q.missing_seen <= mseen_d;
      grp_q.sat_seen <= sat_d;
      grp_q.func <= op_i.func;
      grp_q.columnwise <= columnwise_i;
    end
  end

  assign grp_valid_o = grp_valid_q;
  assign grp_o = grp_q;

endmodule

[rtl/gau_finish.sv]
`timescale 1ns / 1ps
module gau_finish (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               grp_valid_i,
  output logic               grp_ready_o,
  input  gau_pkg::group_t    grp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gau_pkg::out_item_t out_data_o
);

  localparam int NB = gau_pkg::NumBits;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;
  logic [NB-1:0] num_q;
  logic [gau_pkg::WtBits:0] rem_q;
  logic [gau_pkg::WtBits-1:0] den_q;
  logic [NB-1:0] quo_q;
  logic [gau_pkg::NumCntBits-1:0] step_q;
  logic neg_q;
  gau_pkg::out_item_t out_q;

  logic [gau_pkg::AccBits-1:0] mag;
  logic [gau_pkg::AccBits+6:0] scaled;
  logic direct, miss, is_ratio;
  logic [gau_pkg::AccBits-1:0] direct_res;
  logic [gau_pkg::WtBits:0] rem_sh, rem_sub;
  logic [NB-1:0] q_next, q_rnd;
  logic q_big, ovf;
  logic [gau_pkg::AccBits-1:0] fin_res;

  always_comb begin
    miss = 1'b0;
    direct = 1'b1;
    is_ratio = 1'b0;
    direct_res = grp_i.acc;
    if (grp_i.func > gau_pkg::FN_LAST) begin
      miss = 1'b1;
    end else if (grp_i.columnwise && grp_i.missing_seen &&
                 !(grp_i.func inside {gau_pkg::FN_N, gau_pkg::FN_NU,
                                      gau_pkg::FN_NMISS, gau_pkg::FN_NUMISS})) begin
      miss = 1'b1;
    end else if (grp_i.func inside {gau_pkg::FN_SUM, gau_pkg::FN_MAX, gau_pkg::FN_MIN,
                                    gau_pkg::FN_FIRST, gau_pkg::FN_LAST}) begin
      miss = !grp_i.value_seen;
    end else if (grp_i.func inside {gau_pkg::FN_N, gau_pkg::FN_NMISS}) begin
      miss = 1'b0;
    end else if (grp_i.func inside {gau_pkg::FN_NU, gau_pkg::FN_NUMISS}) begin
      direct_res = gau_pkg::AccBits'(grp_i.cnt);
    end else if (grp_i.wt == '0) begin
      miss = 1'b1;
    end else begin
      direct = 1'b0;
      is_ratio = grp_i.func != gau_pkg::FN_MEAN;
    end
    if (is_ratio) mag = grp_i.acc[gau_pkg::AccBits-1] ? '0 : grp_i.acc;
    else mag = grp_i.acc[gau_pkg::AccBits-1] ? -grp_i.acc : grp_i.acc;
    // Percentages scale by 100, fractions and the mean by one.
    if (grp_i.func <= gau_pkg::FN_POUT && is_ratio) scaled = mag * gau_pkg::PctScale;
    else scaled = (gau_pkg::AccBits+7)'(mag);
  end

  // One restoring-division step per cycle.
  assign rem_sh  = {rem_q[gau_pkg::WtBits-1:0], num_q[NB-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign q_next  = {quo_q[NB-2:0], !rem_sub[gau_pkg::WtBits]};

  assign q_big = |quo_q[NB-1:gau_pkg::AccBits-1];
  always_comb begin
    q_rnd = quo_q + NB'(({rem_q, 1'b0} >= {2'b0, den_q}) && !q_big);
    ovf = q_big || (neg_q ? (q_rnd > NB'({1'b1, {(gau_pkg::AccBits-1){1'b0}}}))
                          : (q_rnd > NB'({1'b0, {(gau_pkg::AccBits-1){1'b1}}})));
    if (ovf) fin_res = neg_q ? {1'b1, {(gau_pkg::AccBits-1){1'b0}}}
                             : {1'b0, {(gau_pkg::AccBits-1){1'b1}}};
    else if (neg_q) fin_res = -q_rnd[gau_pkg::AccBits-1:0];
    else fin_res = q_rnd[gau_pkg::AccBits-1:0];
  end

  assign grp_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (grp_valid_i) begin
            if (direct) begin
              out_q.agg_result <= miss ? '0 : direct_res;
              out_q.agg_missing <= miss;
              out_q.agg_saturated <= grp_i.sat_seen;
              state_q <= ST_OUT;
            end else begin
              num_q <= {scaled, {gau_pkg::FractionBits{1'b0}}};
              den_q <= grp_i.wt;
              rem_q <= '0;
              quo_q <= '0;
              neg_q <= !is_ratio && grp_i.acc[gau_pkg::AccBits-1];
              out_q.agg_saturated <= grp_i.sat_seen;
              step_q <= gau_pkg::NumCntBits'(NB);
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (step_q == '0) begin
            out_q.agg_result <= fin_res;
            out_q.agg_missing <= 1'b0;
            out_q.agg_saturated <= out_q.agg_saturated || ovf;
            state_q <= ST_OUT;
          end else begin
            rem_q <= rem_sub[gau_pkg::WtBits] ? rem_sh : rem_sub;
            quo_q <= q_next;
            num_q <= {num_q[NB-2:0], 1'b0};
            step_q <= step_q - 1'b1;
          end
        end
        ST_OUT: begin
          if (out_ready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.agg_missing |-> out_data_o.agg_result == '0)
    else $error("missing result not zero");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> !grp_ready_o)
    else $error("group taken during division");
`endif

endmodule

[rtl/group_aggregate_unit_top.sv]
`timescale 1ns / 1ps
// Group aggregation over presorted, weighted samples.
// Input channel (in_valid_i/in_ready_o/in_data_i): one sample per transfer,
// with value, weight, missing flag and last-of-group mark.
// Output channel (out_valid_o/out_ready_i/out_data_o): one result per group,
// sent after the transfer that carries the last-of-group mark.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): 0 func_select,
// 1 arg_low, 2 arg_high, 3 columnwise; write only while the block is idle.
// Throughput: the accumulator takes one transfer a cycle from a two-entry queue
// fed by the classifying front end; after a group end it stalls until the finish
// stage, busy in the divider or holding a result at the output, takes that group.
// Integer results pass through the group snapshot and the output register after
// the last sample's transfer; mean, fraction and percentage results run through a
// restoring divider, one quotient bit a cycle, for 87 bits, then a rounding step.
// Reset clears configuration to zero and all accumulators.
// When the receiver stalls, the result holds, the divider idles, and the
// queue fills, after which in_ready_o drops.
module group_aggregate_unit_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gau_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gau_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [gau_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic [4:0] func_q;
  logic signed [31:0] low_q, high_q;
  logic colw_q;
  logic op_valid, op_ready, grp_valid, grp_ready;
  gau_pkg::op_t op;
  gau_pkg::group_t grp;

  assign cfg_ready_o = 1'b1;

  // Hold configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q <= '0;
      low_q <= '0;
      high_q <= '0;
      colw_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gau_pkg::REG_FUNC:    func_q <= cfg_data_i[4:0];
        gau_pkg::REG_LOW:     low_q <= cfg_data_i;
        gau_pkg::REG_HIGH:    high_q <= cfg_data_i;
        gau_pkg::REG_COLWISE: colw_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  gau_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .func_i(func_q), .arg_low_i(low_q), .arg_high_i(high_q),
    .op_valid_o(op_valid), .op_ready_i(op_ready), .op_o(op)
  );

  gau_accum u_accum (
    .clk_i, .rst_ni, .columnwise_i(colw_q),
    .op_valid_i(op_valid), .op_ready_o(op_ready), .op_i(op),
    .grp_valid_o(grp_valid), .grp_ready_i(grp_ready), .grp_o(grp)
  );

  gau_finish u_finish (
    .clk_i, .rst_ni,
    .grp_valid_i(grp_valid), .grp_ready_o(grp_ready), .grp_i(grp),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
